[sv/rwcs_pkg.sv]
package rwcs_pkg;

  // Defaults for the top-level parameters.
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths.
  localparam int DIST_W = 24;
  localparam int DIR_W  = 20;
  localparam int POS_W  = 24;
  localparam int TEX_W  = 11;
  localparam int ROW_W  = 12;
  localparam int FACE_W = 2;
  localparam int COL_W  = 10;
  localparam int STEP_W = 26;
  // Row offset is held saturated at one above the largest step value.
  localparam int OFS_W  = STEP_W + 1;

  localparam logic [TEX_W-1:0]  TEX_RESET = 11'd64;
  localparam logic [STEP_W-1:0] STEP_MAX  = '1;

  // Wall face codes.
  localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
  localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
  localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TEXTURE_WIDTH  = 1'b0;
  localparam logic CFG_TEXTURE_HEIGHT = 1'b1;

  // One finished column result.
  typedef struct packed {
    logic [ROW_W-1:0]  row_first;
    logic [ROW_W-1:0]  row_last;
    logic [FACE_W-1:0] face;
    logic [COL_W-1:0]  column;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] row_start;
  } col_item_t;

endpackage

[sv/rwcs_front.sv]
module rwcs_front
  import rwcs_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [DIST_W-1:0]        wall_distance,
  input  logic                     wall_side,
  input  logic signed [DIR_W-1:0]  dir_x_in,
  input  logic signed [DIR_W-1:0]  dir_y_in,
  input  logic [POS_W-1:0]         player_x,
  input  logic [POS_W-1:0]         player_y,
  input  logic [TEX_W-1:0]         texture_width,
  output logic                     out_valid,
  output logic [DIST_W-1:0]        out_dist,
  output logic [FACE_W-1:0]        out_face,
  output logic [COL_W-1:0]         out_column
);

  localparam int MinRaw  = ((1 << FRACTION_BITS) + 5000) / 10000;
  localparam int MinDist = (MinRaw == 0) ? 1 : MinRaw;
  localparam int ProdW   = DIST_W + 1 + DIR_W;
  localparam int ExtW    = (2 * FRACTION_BITS > ProdW) ? 2 * FRACTION_BITS : ProdW;
  localparam int FpW     = FRACTION_BITS + TEX_W;

  // Stage A: distance floor, face and hit-axis selection.
  logic [DIST_W-1:0]        dist_c;
  logic signed [DIR_W-1:0]  dcomp_c;
  logic [POS_W-1:0]         base_c;
  logic [FACE_W-1:0]        face_c;
  logic                     mirror_c;

  always_comb begin
    dist_c = (wall_distance < DIST_W'(MinDist)) ? DIST_W'(MinDist) : wall_distance;
    if (wall_side == 1'b0) begin
      face_c   = (dir_x_in > 0) ? FACE_EAST : FACE_WEST;
      mirror_c = (dir_x_in > 0);
      dcomp_c  = dir_y_in;
      base_c   = player_y;
    end else begin
      face_c   = (dir_y_in > 0) ? FACE_SOUTH : FACE_NORTH;
      mirror_c = (dir_y_in < 0);
      dcomp_c  = dir_x_in;
      base_c   = player_x;
    end
  end

  logic                        va_r, vb_r, vc_r, vd_r;
  logic [DIST_W-1:0]           dist_a_r, dist_b_r, dist_c_r, dist_d_r;
  logic signed [DIR_W-1:0]     dcomp_a_r;
  logic [FRACTION_BITS-1:0]    base_a_r, base_b_r;
  logic [FACE_W-1:0]           face_a_r, face_b_r, face_c_r, face_d_r;
  logic                        mirror_a_r, mirror_b_r, mirror_c_r;
  logic signed [ProdW-1:0]     prod_b_r;
  logic [FpW-1:0]              fprod_c_r;
  logic [COL_W-1:0]            col_d_r;

  // Stage C inputs: hit fraction from the exact product.
  logic signed [ExtW-1:0]      prod_ext;
  logic [FRACTION_BITS-1:0]    frac;
  // Stage D inputs: texel column and its mirror.
  logic [TEX_W-1:0]            col_raw;
  logic [TEX_W-1:0]            col_sel;

  always_comb begin
    prod_ext = ExtW'(prod_b_r);
    frac     = base_b_r + prod_ext[2*FRACTION_BITS-1:FRACTION_BITS];
    col_raw  = fprod_c_r[FpW-1:FRACTION_BITS];
    col_sel  = mirror_c_r ? (texture_width - col_raw - 11'd1) : col_raw;
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // Data path of the four stages.
  always_ff @(posedge clk) begin
    if (en) begin
      dist_a_r   <= dist_c;
      dcomp_a_r  <= dcomp_c;
      base_a_r   <= base_c[FRACTION_BITS-1:0];
      face_a_r   <= face_c;
      mirror_a_r <= mirror_c;

      prod_b_r   <= $signed({1'b0, dist_a_r}) * dcomp_a_r;
      base_b_r   <= base_a_r;
      dist_b_r   <= dist_a_r;
      face_b_r   <= face_a_r;
      mirror_b_r <= mirror_a_r;

      fprod_c_r  <= FpW'(frac) * FpW'(texture_width);
      dist_c_r   <= dist_b_r;
      face_c_r   <= face_b_r;
      mirror_c_r <= mirror_b_r;

      col_d_r    <= col_sel[COL_W-1:0];
      dist_d_r   <= dist_c_r;
      face_d_r   <= face_c_r;
    end
  end

  assign out_valid  = vd_r;
  assign out_dist   = dist_d_r;
  assign out_face   = face_d_r;
  assign out_column = col_d_r;

endmodule

[sv/rwcs_div.sv]
module rwcs_div
  import rwcs_pkg::*;
#(
  parameter int NUMW = 26,
  parameter int DENW = 24,
  parameter int PW   = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic [PW-1:0]   pay,
  output logic            out_valid,
  output logic [NUMW-1:0] quo,
  output logic [PW-1:0]   out_pay
);

  // Restoring division, one quotient bit per stage.
  logic            v_r   [NUMW];
  logic [DENW-1:0] rem_r [NUMW];
  logic [NUMW-1:0] num_r [NUMW];
  logic [NUMW-1:0] quo_r [NUMW];
  logic [DENW-1:0] den_r [NUMW];
  logic [PW-1:0]   pay_r [NUMW];

  for (genvar k = 0; k < NUMW; k++) begin : g_stage
    logic            v_i;
    logic [DENW-1:0] rem_i;
    logic [NUMW-1:0] num_i;
    logic [NUMW-1:0] quo_i;
    logic [DENW-1:0] den_i;
    logic [PW-1:0]   pay_i;
    logic [DENW:0]   trial;
    logic [DENW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign num_i = num;
      assign quo_i = '0;
      assign den_i = den;
      assign pay_i = pay;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign num_i = num_r[k-1];
      assign quo_i = quo_r[k-1];
      assign den_i = den_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
      trial = {rem_i, num_i[NUMW-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        num_r[k] <= num_i << 1;
        quo_r[k] <= {quo_i[NUMW-2:0], ge};
        den_r[k] <= den_i;
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = v_r[NUMW-1];
  assign quo       = quo_r[NUMW-1];
  assign out_pay   = pay_r[NUMW-1];

endmodule

[sv/rwcs_rows.sv]
module rwcs_rows
  import rwcs_pkg::*;
#(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int HW            = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [HW-1:0]     height,
  input  logic [FACE_W-1:0] face,
  input  logic [COL_W-1:0]  column,
  output logic              out_valid,
  output logic [HW-1:0]     out_height,
  output logic              out_height_zero,
  output logic [ROW_W-1:0]  out_row_first,
  output logic [ROW_W-1:0]  out_row_last,
  output logic [OFS_W-1:0]  out_offset,
  output logic [FACE_W-1:0] out_face,
  output logic [COL_W-1:0]  out_column
);

  localparam int HalfScreen = SCREEN_HEIGHT / 2;
  localparam int OxW        = (HW > OFS_W) ? HW : OFS_W;

  logic [HW-1:0]  half_h;
  logic           above;
  logic [HW:0]    sum;
  logic [HW-1:0]  diff;
  logic [OxW-1:0] diff_x;
  logic [ROW_W-1:0] first_c, last_c;
  logic [OFS_W-1:0] offset_c;

  // Slice rows around the screen centre and the clipped row offset.
  always_comb begin
    half_h   = height >> 1;
    above    = (half_h >= HW'(HalfScreen));
    sum      = {1'b0, half_h} + (HW + 1)'(HalfScreen);
    diff     = above ? (half_h - HW'(HalfScreen)) : '0;
    diff_x   = OxW'(diff);
    first_c  = above ? '0 : ROW_W'(HW'(HalfScreen) - half_h);
    last_c   = (sum >= (HW + 1)'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                  : ROW_W'(sum);
    offset_c = (diff_x > OxW'(STEP_MAX)) ? {1'b1, {STEP_W{1'b0}}}
                                         : OFS_W'(diff_x);
  end

  logic v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_height      <= height;
      out_height_zero <= (height == '0);
      out_row_first   <= first_c;
      out_row_last    <= last_c;
      out_offset      <= offset_c;
      out_face        <= face;
      out_column      <= column;
    end
  end

  assign out_valid = v_r;

endmodule

[sv/rwcs_back.sv]
module rwcs_back
  import rwcs_pkg::*;
#(
  parameter int QW = 27
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW-1:0]     quo,
  input  logic              height_zero,
  input  logic [ROW_W-1:0]  row_first,
  input  logic [ROW_W-1:0]  row_last,
  input  logic [OFS_W-1:0]  offset,
  input  logic [FACE_W-1:0] face,
  input  logic [COL_W-1:0]  column,
  output logic              out_valid,
  output col_item_t         out_item
);

  localparam int QxW   = (QW > OFS_W) ? QW : OFS_W;
  localparam int ProdW = OFS_W + STEP_W;

  logic [QxW-1:0]    quo_x;
  logic [STEP_W-1:0] step_c;
  logic [ProdW-1:0]  prod_x;
  col_item_t         item3_c;

  logic              v1_r, v2_r, v3_r;
  logic [STEP_W-1:0] step1_r, step2_r;
  logic [OFS_W-1:0]  offset1_r;
  logic [ProdW-1:0]  prod2_r;
  col_item_t         item1_r, item2_r, item3_r;

  // Step saturation, zero line height gives the largest step.
  always_comb begin
    quo_x  = QxW'(quo);
    if (height_zero) begin
      step_c = STEP_MAX;
    end else if (quo_x > QxW'(STEP_MAX)) begin
      step_c = STEP_MAX;
    end else begin
      step_c = STEP_W'(quo_x);
    end
    prod_x = prod2_r;
    // Final word: step and saturated start row merged into the carried fields.
    item3_c           = item2_r;
    item3_c.step      = step2_r;
    item3_c.row_start = (prod_x > ProdW'(STEP_MAX)) ? STEP_MAX : STEP_W'(prod_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Step, then the start-row product, then its saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      step1_r           <= step_c;
      offset1_r         <= offset;
      item1_r.row_first <= row_first;
      item1_r.row_last  <= row_last;
      item1_r.face      <= face;
      item1_r.column    <= column;
      item1_r.step      <= '0;
      item1_r.row_start <= '0;

      prod2_r           <= ProdW'(offset1_r) * ProdW'(step1_r);
      step2_r           <= step1_r;
      item2_r           <= item1_r;

      item3_r           <= item3_c;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item3_r;

endmodule

[sv/raycast_wall_column_setup_top.sv]
// An accepted input word passes the front, the line height divider, the slice rows,
// the texture step divider and the back stage, then the output buffer.
// The two dividers (line height, texture step) produce one quotient bit per stage.
// Throughput: one column word per cycle while the two-word output buffer is not full.
// Reset (rst_n low, synchronous) empties the pipeline and buffer and sets both
// texture sizes to 64.
module raycast_wall_column_setup_top
  import rwcs_pkg::*;
#(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // wall distance[23:0], direction x[43:24], direction y[63:44], player_x[87:64],
  // player_y[111:88]
  input  logic [111:0]       in_tdata,
  // wall_side[0]
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // slice first row[11:0], slice end row[23:12], texture_column[33:24],
  // texture_step[59:34], texture_row_start[85:60], zero[87:86]
  output logic [87:0]        out_tdata,
  // wall_face[1:0]
  output logic [FACE_W-1:0]  out_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [TEX_W-1:0]   cfg_data
);

  localparam int ShW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int HW    = ShW + FRACTION_BITS;
  localparam int Num2W = TEX_W + FRACTION_BITS;
  localparam int Pay1W = FACE_W + COL_W;
  localparam int Pay2W = FACE_W + COL_W + 2 * ROW_W + OFS_W + 1;

  // Configuration registers.
  logic [TEX_W-1:0] tex_width_r, tex_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= TEX_RESET;
      tex_height_r <= TEX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXTURE_WIDTH:  tex_width_r  <= cfg_data;
        CFG_TEXTURE_HEIGHT: tex_height_r <= cfg_data;
      endcase
    end
  end

  // Pipeline advance, held only while the output buffer is full.
  logic [1:0] count_r, count_nxt;
  logic       en;

  assign en        = (count_r != 2'd2);
  assign in_tready = en;

  // Front: hit point and texture column.
  logic              fr_valid;
  logic [DIST_W-1:0] fr_dist;
  logic [FACE_W-1:0] fr_face;
  logic [COL_W-1:0]  fr_column;

  rwcs_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid),
    .wall_distance (in_tdata[23:0]),
    .wall_side     (in_tuser),
    .dir_x_in      ($signed(in_tdata[43:24])),
    .dir_y_in      ($signed(in_tdata[63:44])),
    .player_x      (in_tdata[87:64]),
    .player_y      (in_tdata[111:88]),
    .texture_width (tex_width_r),
    .out_valid     (fr_valid),
    .out_dist      (fr_dist),
    .out_face      (fr_face),
    .out_column    (fr_column)
  );

  // Line height divider.
  logic             d1_valid;
  logic [HW-1:0]    d1_height;
  logic [Pay1W-1:0] d1_pay;

  rwcs_div #(
    .NUMW (HW),
    .DENW (DIST_W),
    .PW   (Pay1W)
  ) u_div_height (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .num       (HW'(SCREEN_HEIGHT) << FRACTION_BITS),
    .den       (fr_dist),
    .pay       ({fr_face, fr_column}),
    .out_valid (d1_valid),
    .quo       (d1_height),
    .out_pay   (d1_pay)
  );

  // Slice rows.
  logic              rw_valid;
  logic [HW-1:0]     rw_height;
  logic              rw_zero;
  logic [ROW_W-1:0]  rw_first, rw_last;
  logic [OFS_W-1:0]  rw_offset;
  logic [FACE_W-1:0] rw_face;
  logic [COL_W-1:0]  rw_column;

  rwcs_rows #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .HW            (HW)
  ) u_rows (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (d1_valid),
    .height          (d1_height),
    .face            (d1_pay[Pay1W-1:COL_W]),
    .column          (d1_pay[COL_W-1:0]),
    .out_valid       (rw_valid),
    .out_height      (rw_height),
    .out_height_zero (rw_zero),
    .out_row_first   (rw_first),
    .out_row_last    (rw_last),
    .out_offset      (rw_offset),
    .out_face        (rw_face),
    .out_column      (rw_column)
  );

  // Texture step divider.
  logic             d2_valid;
  logic [Num2W-1:0] d2_step;
  logic [Pay2W-1:0] d2_pay;

  rwcs_div #(
    .NUMW (Num2W),
    .DENW (HW),
    .PW   (Pay2W)
  ) u_div_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rw_valid),
    .num       ({tex_height_r, {FRACTION_BITS{1'b0}}}),
    .den       (rw_height),
    .pay       ({rw_face, rw_column, rw_first, rw_last, rw_offset, rw_zero}),
    .out_valid (d2_valid),
    .quo       (d2_step),
    .out_pay   (d2_pay)
  );

  // Step saturation and texture start row.
  logic      bk_valid;
  col_item_t bk_item;

  rwcs_back #(
    .QW (Num2W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (d2_valid),
    .quo         (d2_step),
    .height_zero (d2_pay[0]),
    .offset      (d2_pay[OFS_W:1]),
    .row_last    (d2_pay[OFS_W+ROW_W:OFS_W+1]),
    .row_first   (d2_pay[OFS_W+2*ROW_W:OFS_W+ROW_W+1]),
    .column      (d2_pay[OFS_W+2*ROW_W+COL_W:OFS_W+2*ROW_W+1]),
    .face        (d2_pay[Pay2W-1:Pay2W-FACE_W]),
    .out_valid   (bk_valid),
    .out_item    (bk_item)
  );

  // Two-word output buffer; slot 0 is the word on offer.
  col_item_t slot0_r, slot1_r, slot0_nxt, slot1_nxt;
  logic      push, pop;

  always_comb begin
    push      = en && bk_valid;
    pop       = out_tvalid && out_tready;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop && count_r == 2'd2) begin
      slot0_nxt = slot1_r;
    end
    if (push) begin
      if (count_r == 2'd0 || (count_r == 2'd1 && pop)) begin
        slot0_nxt = bk_item;
      end else begin
        slot1_nxt = bk_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_tvalid = (count_r != 2'd0);
  assign out_tuser  = slot0_r.face;
  assign out_tdata  = {2'b00, slot0_r.row_start, slot0_r.step, slot0_r.column,
                       slot0_r.row_last, slot0_r.row_first};

  // The slice never starts below its end row.
  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (slot0_r.row_first <= slot0_r.row_last))
    else $error("slice first row after its end row");

  // The end row stays on the screen.
  a_rows_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(slot0_r.row_last) < SCREEN_HEIGHT))
    else $error("slice end row off screen");

  // An unclipped slice starts at texture row zero.
  a_start_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && slot0_r.row_first != '0) |-> (slot0_r.row_start == '0))
    else $error("texture row start nonzero for unclipped slice");

endmodule
